@@ design/pal_pkg.sv @@
// shared types, codes and field widths for the positional array list
package pal_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 16;

  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 16;
  localparam int STAT_W   = 2;
  localparam int IN_BITS  = OP_W + POS_W + VAL_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // memory address sources
  localparam logic [1:0] ADDR_PTR    = 2'd0;
  localparam logic [1:0] ADDR_PTR_M1 = 2'd1;
  localparam logic [1:0] ADDR_POS_M1 = 2'd2;

  typedef struct packed {
    logic       load;
    logic       st_latch;
    logic       ptr_from_count;
    logic       ptr_from_pos;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       wr_val;
    logic       capture;
    logic       count_inc;
    logic       count_dec;
    logic       count_clr;
    logic       out_load;
  } pal_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            ptr_ge_pos;
    logic            ptr_lt_count;
    logic            out_free;
  } pal_stat_t;

endpackage

@@ design/pal_ctrl.sv @@
// request sequencer: steps the datapath through each operation
module pal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pal_pkg::pal_stat_t stat,
  output pal_pkg::pal_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_INS_TEST = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_DEL_CAP  = 4'd4;
  localparam logic [3:0] S_DEL_TEST = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_RET_CAP  = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.st_latch = 1'b1;
        state_next   = S_FINISH;
        if (!stat.err) begin
          case (stat.op)
            pal_pkg::OP_INSERT: begin
              cmd.ptr_from_count = 1'b1;
              state_next         = S_INS_TEST;
            end
            pal_pkg::OP_DELETE: begin
              cmd.rd_en        = 1'b1;
              cmd.rd_sel       = pal_pkg::ADDR_POS_M1;
              cmd.ptr_from_pos = 1'b1;
              state_next       = S_DEL_CAP;
            end
            pal_pkg::OP_RETRIEVE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = pal_pkg::ADDR_POS_M1;
              state_next = S_RET_CAP;
            end
            pal_pkg::OP_REPLACE: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = pal_pkg::ADDR_POS_M1;
              cmd.wr_val = 1'b1;
            end
            pal_pkg::OP_CLEAR: begin
              cmd.count_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_TEST: begin
        if (stat.ptr_ge_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pal_pkg::ADDR_PTR_M1;
          state_next = S_INS_WR;
        end else begin
          // pointer has reached the gap at pos-1
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = pal_pkg::ADDR_PTR;
          cmd.wr_val    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = pal_pkg::ADDR_PTR;
        cmd.ptr_dec = 1'b1;
        state_next  = S_INS_TEST;
      end
      S_DEL_CAP: begin
        cmd.capture = 1'b1;
        state_next  = S_DEL_TEST;
      end
      S_DEL_TEST: begin
        if (stat.ptr_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pal_pkg::ADDR_PTR;
          state_next = S_DEL_WR;
        end else begin
          cmd.count_dec = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = pal_pkg::ADDR_PTR_M1;
        cmd.ptr_inc = 1'b1;
        state_next  = S_DEL_TEST;
      end
      S_RET_CAP: begin
        cmd.capture = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/pal_dp.sv @@
// datapath: entry memory, count, shift pointer, request checks and result register
module pal_dp #(
  parameter int DEPTH      = pal_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = pal_pkg::ITEM_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pal_pkg::OP_W-1:0]    op,
  input  logic [pal_pkg::POS_W-1:0]   position,
  input  logic [pal_pkg::VAL_W-1:0]   item_value,
  input  pal_pkg::pal_cmd_t           cmd,
  output pal_pkg::pal_stat_t          stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pal_pkg::VAL_W-1:0]   item_out,
  output logic [pal_pkg::STAT_W-1:0]  status,
  output logic [CW-1:0]               count_out,
  output logic                        is_empty,
  output logic                        is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > pal_pkg::POS_W) ? CW + 1 : pal_pkg::POS_W + 1;

  logic [ITEM_WIDTH-1:0]          mem [DEPTH];
  logic [pal_pkg::OP_W-1:0]       op_q;
  logic [pal_pkg::POS_W-1:0]      pos_q;
  logic [ITEM_WIDTH-1:0]          val_q;
  logic [pal_pkg::STAT_W-1:0]     req_status;
  logic [pal_pkg::STAT_W-1:0]     chk_status;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  ptr;
  logic [ITEM_WIDTH-1:0]          rdata;
  logic [pal_pkg::VAL_W-1:0]      item;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] ptr_ext;
  logic [PW-1:0] pos_m1;
  logic [CW-1:0] ptr_m1;
  logic          pos_zero;
  logic          list_full;
  logic          list_empty;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;

  assign pos_ext    = PW'(pos_q);
  assign cnt_ext    = PW'(count);
  assign ptr_ext    = PW'(ptr);
  assign pos_m1     = pos_ext - PW'(1);
  assign ptr_m1     = ptr - CW'(1);
  assign pos_zero   = (pos_q == '0);
  assign list_full  = (count == CW'(DEPTH));
  assign list_empty = (count == '0);

  // full and empty checks come before the position check
  always_comb begin
    chk_status = pal_pkg::ST_OK;
    case (op_q)
      pal_pkg::OP_INSERT: begin
        if (list_full) begin
          chk_status = pal_pkg::ST_FULL;
        end else if (pos_zero || pos_ext > cnt_ext + PW'(1)) begin
          chk_status = pal_pkg::ST_BADPOS;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (list_empty) begin
          chk_status = pal_pkg::ST_EMPTY;
        end else if (pos_zero || pos_ext > cnt_ext) begin
          chk_status = pal_pkg::ST_BADPOS;
        end
      end
      pal_pkg::OP_RETRIEVE, pal_pkg::OP_REPLACE: begin
        if (pos_zero || pos_ext > cnt_ext) begin
          chk_status = pal_pkg::ST_BADPOS;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.op           = op_q;
  assign stat.err          = (chk_status != pal_pkg::ST_OK);
  assign stat.ptr_ge_pos   = (ptr_ext >= pos_ext);
  assign stat.ptr_lt_count = (ptr < count);
  assign stat.out_free     = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      pal_pkg::ADDR_PTR:    rd_addr = ptr[AW-1:0];
      pal_pkg::ADDR_PTR_M1: rd_addr = ptr_m1[AW-1:0];
      default:              rd_addr = pos_m1[AW-1:0];
    endcase
    case (cmd.wr_sel)
      pal_pkg::ADDR_PTR:    wr_addr = ptr[AW-1:0];
      pal_pkg::ADDR_PTR_M1: wr_addr = ptr_m1[AW-1:0];
      default:              wr_addr = pos_m1[AW-1:0];
    endcase
    wr_data = cmd.wr_val ? val_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      pos_q <= position;
      val_q <= ITEM_WIDTH'(item_value);
      item  <= '0;
    end else if (cmd.capture) begin
      item <= pal_pkg::VAL_W'(rdata);
    end
    if (cmd.st_latch) begin
      req_status <= chk_status;
    end
    if (cmd.ptr_from_count) begin
      ptr <= count;
    end else if (cmd.ptr_from_pos) begin
      ptr <= CW'(pos_q);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_m1;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_clr) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      item_out  <= item;
      status    <= req_status;
      count_out <= count;
      is_empty  <= list_empty;
      is_full   <= list_full;
    end
  end

endmodule

@@ design/positional_array_list.sv @@
// top level of the positional array list: stream ports, sequencer and datapath
//
//  channel   dir  beat contents (tdata from bit 0 up)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   op[2:0], position[10:3], item_value[26:11], zero pad
//  m_axis    out  item_out[15:0], status[17:16], count_out, is_empty, is_full
//
// one request is worked at a time; s_tready is high only while idle and out of reset
// replace, clear, unused ops and errors go from the check straight to the result;
// retrieve reads and captures the entry first; insert shifts entries up from the end
// and delete captures the entry at p and shifts later ones down, each by a read then a write
// a stalled result holds the sequencer, and s_tready with it, until m_tready takes the beat
// synchronous reset empties the list; entry contents are not cleared
module positional_array_list #(
  parameter int DEPTH       = pal_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH  = pal_pkg::ITEM_WIDTH_DEF,
  localparam int CW         = $clog2(DEPTH + 1),
  localparam int OUT_BITS   = pal_pkg::VAL_W + pal_pkg::STAT_W + CW + 2,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // op, position, item_value
  input  logic [pal_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // item_out, status, count_out, is_empty, is_full
  output logic [OUT_TDATA_W-1:0]        m_tdata
);

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;

  logic [pal_pkg::OP_W-1:0]   op;
  logic [pal_pkg::POS_W-1:0]  position;
  logic [pal_pkg::VAL_W-1:0]  item_value;
  logic [pal_pkg::VAL_W-1:0]  item_out;
  logic [pal_pkg::STAT_W-1:0] status;
  logic [CW-1:0]              count_out;
  logic                       is_empty;
  logic                       is_full;

  // unpack the request beat
  assign op         = s_tdata[pal_pkg::OP_W-1:0];
  assign position   = s_tdata[pal_pkg::OP_W +: pal_pkg::POS_W];
  assign item_value = s_tdata[pal_pkg::OP_W + pal_pkg::POS_W +: pal_pkg::VAL_W];

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pal_dp #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .position   (position),
    .item_value (item_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .item_out   (item_out),
    .status     (status),
    .count_out  (count_out),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  // pack the result beat, zero filled to whole bytes
  assign m_tdata = OUT_TDATA_W'({is_full, is_empty, count_out, status, item_out});

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the positional array list stream block
module tb;

  localparam int DEPTH         = pal_pkg::DEPTH_DEF;
  localparam int ITEM_WIDTH    = pal_pkg::ITEM_WIDTH_DEF;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int OUT_BITS      = pal_pkg::VAL_W + pal_pkg::STAT_W + CNT_W + 2;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int RESET_CYCLES  = 12;
  // longest quiet stretch of a good run is the long hold-off plus one
  // worst-case shift and a sender gap; several times over
  localparam int STALL_LIMIT   = 2000;
  // worst insert moves DEPTH - 1 entries, every slot but one
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam logic [pal_pkg::VAL_W-1:0] ITEM_MASK =
    pal_pkg::VAL_W'((64'd1 << ITEM_WIDTH) - 64'd1);

  // request beat, lowest field first in tdata
  typedef struct packed {
    logic [pal_pkg::VAL_W-1:0] value;
    logic [pal_pkg::POS_W-1:0] pos;
    logic [pal_pkg::OP_W-1:0]  op;
  } list_req_t;

  // result beat, lowest field first in tdata
  typedef struct packed {
    logic                       full;
    logic                       empty;
    logic [CNT_W-1:0]           count;
    logic [pal_pkg::STAT_W-1:0] status;
    logic [pal_pkg::VAL_W-1:0]  word;
  } list_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [pal_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]         m_tdata;

  // shadow copy of the list, advanced once per accepted request beat
  logic [pal_pkg::VAL_W-1:0] list_words [DEPTH];
  int                        list_count = 0;

  // results still owed by the block, oldest first
  list_result_t pending_results [$];
  int           mismatches = 0;
  int           result_index = 0;

  // sender burst state
  int tx_burst_left = 0;
  bit tx_gaps_on = 1'b1;

  // long receiver hold-off: the test bumps hold_serial, the receiver counts
  int hold_serial = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  positional_array_list #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    // op, position, item_value, zero pad
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    // item_out, status, count_out, is_empty, is_full
    .m_tdata  (m_tdata)
  );

  // list behavior for one request; updates the shadow list
  function automatic list_result_t apply_request(input list_req_t req);
    list_result_t res;
    res = '0;
    case (req.op)
      pal_pkg::OP_INSERT: begin
        // full check wins over the position check
        if (list_count >= DEPTH) begin
          res.status = pal_pkg::ST_FULL;
        end else if (req.pos < 1 || req.pos > list_count + 1) begin
          res.status = pal_pkg::ST_BADPOS;
        end else begin
          for (int i = list_count; i >= req.pos; i--) list_words[i] = list_words[i - 1];
          list_words[req.pos - 1] = req.value & ITEM_MASK;
          list_count++;
        end
      end
      pal_pkg::OP_DELETE: begin
        // empty check wins over the position check
        if (list_count == 0) begin
          res.status = pal_pkg::ST_EMPTY;
        end else if (req.pos < 1 || req.pos > list_count) begin
          res.status = pal_pkg::ST_BADPOS;
        end else begin
          res.word = list_words[req.pos - 1];
          for (int i = req.pos; i < list_count; i++) list_words[i - 1] = list_words[i];
          list_count--;
        end
      end
      pal_pkg::OP_RETRIEVE: begin
        if (req.pos < 1 || req.pos > list_count) res.status = pal_pkg::ST_BADPOS;
        else res.word = list_words[req.pos - 1];
      end
      pal_pkg::OP_REPLACE: begin
        if (req.pos < 1 || req.pos > list_count) res.status = pal_pkg::ST_BADPOS;
        else list_words[req.pos - 1] = req.value & ITEM_MASK;
      end
      pal_pkg::OP_CLEAR: list_count = 0;
      default: ;  // unused op codes leave the list alone
    endcase
    res.count = CNT_W'(list_count);
    res.empty = (list_count == 0);
    res.full  = (list_count == DEPTH);
    return res;
  endfunction

  // offer one request beat, with a random gap before a new burst while gaps are on
  task automatic send_request(input logic [pal_pkg::OP_W-1:0] op, input int pos,
                              input logic [pal_pkg::VAL_W-1:0] value);
    list_req_t req;
    req.op    = op;
    req.pos   = pal_pkg::POS_W'(pos);
    req.value = value;
    if (tx_gaps_on && tx_burst_left == 0) begin
      s_tvalid <= 1'b0;
      // mostly short gaps, now and then one longer than a full shift
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 45 : 6)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 12);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(pal_pkg::IN_TDATA_W - pal_pkg::IN_BITS){1'b0}}, req};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(req));
  endtask

  // sender pause until every owed result has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random position: mostly in range with the ends favored, some out of range
  function automatic int pick_pos(input logic [pal_pkg::OP_W-1:0] op);
    int top;
    top = (op == pal_pkg::OP_INSERT) ? list_count + 1 : list_count;
    if (top < 1 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: return 0;
        1: return $urandom_range(top + 1, 255);
        default: return $urandom_range(0, 255);
      endcase
    end
    case ($urandom_range(0, 4))
      0: return 1;
      1: return top;
      default: return $urandom_range(1, top);
    endcase
  endfunction

  // one random request; grow_pct steers inserts against deletes
  task automatic random_request(input int grow_pct);
    int roll;
    logic [pal_pkg::OP_W-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 1) op = pal_pkg::OP_CLEAR;
    else if (roll < 3) op = pal_pkg::OP_W'($urandom_range(pal_pkg::OP_CLEAR + 1,
                                                          (1 << pal_pkg::OP_W) - 1));
    else if (roll < 19) op = pal_pkg::OP_RETRIEVE;
    else if (roll < 29) op = pal_pkg::OP_REPLACE;
    else if ($urandom_range(0, 99) < grow_pct) op = pal_pkg::OP_INSERT;
    else op = pal_pkg::OP_DELETE;
    send_request(op, pick_pos(op), pal_pkg::VAL_W'($urandom));
  endtask

  // error codes on an empty list, a short list built and taken apart, unused ops and clears
  task automatic test_empty_and_small_list();
    send_request(pal_pkg::OP_RETRIEVE, 1, 16'h1234);
    send_request(pal_pkg::OP_REPLACE, 1, 16'h1234);
    send_request(pal_pkg::OP_DELETE, 0, 16'h0000);
    send_request(pal_pkg::OP_DELETE, 255, 16'hFFFF);
    send_request(pal_pkg::OP_INSERT, 0, 16'hFFFF);
    send_request(pal_pkg::OP_INSERT, 2, 16'hFFFF);
    send_request(pal_pkg::OP_INSERT, 1, 16'hFFFF);
    send_request(pal_pkg::OP_INSERT, 1, 16'h0000);
    send_request(pal_pkg::OP_INSERT, 3, 16'h8001);
    send_request(pal_pkg::OP_INSERT, 255, 16'h7FFE);
    send_request(pal_pkg::OP_RETRIEVE, 1, 16'h0000);
    send_request(pal_pkg::OP_RETRIEVE, 3, 16'h0000);
    send_request(pal_pkg::OP_RETRIEVE, 4, 16'h0000);
    send_request(pal_pkg::OP_REPLACE, 2, 16'h5A5A);
    send_request(pal_pkg::OP_RETRIEVE, 2, 16'hA5A5);
    send_request(pal_pkg::OP_DELETE, 0, 16'h0000);
    send_request(pal_pkg::OP_DELETE, 4, 16'h0000);
    send_request(pal_pkg::OP_DELETE, 2, 16'h0000);
    // unused op codes come back as plain ok beats
    for (int code = pal_pkg::OP_CLEAR + 1; code < (1 << pal_pkg::OP_W); code++) begin
      send_request(pal_pkg::OP_W'(code), 255, 16'hFFFF);
    end
    send_request(pal_pkg::OP_CLEAR, 0, 16'h0000);
    send_request(pal_pkg::OP_CLEAR, 255, 16'hFFFF);
    send_request(pal_pkg::OP_RETRIEVE, 1, 16'h0000);
  endtask

  // fill to DEPTH, hit the full cases, then drain to empty
  task automatic test_full_list();
    while (list_count < DEPTH) send_request(pal_pkg::OP_INSERT,
                                            $urandom_range(1, list_count + 1),
                                            pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_INSERT, 1, pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_INSERT, DEPTH + 1, pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_INSERT, 255, pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_REPLACE, DEPTH, pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_RETRIEVE, DEPTH, pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_RETRIEVE, DEPTH + 1, pal_pkg::VAL_W'($urandom));
    while (list_count > 0) send_request(pal_pkg::OP_DELETE, $urandom_range(1, list_count),
                                        pal_pkg::VAL_W'($urandom));
    send_request(pal_pkg::OP_DELETE, 1, pal_pkg::VAL_W'($urandom));
  endtask

  // receiver holds off long while the sender keeps offering beats
  task automatic test_long_holdoff();
    tx_gaps_on = 1'b0;
    hold_serial <= hold_serial + 1;
    repeat (25) random_request(60);
    tx_gaps_on = 1'b1;
  endtask

  // phases that grow, churn or shrink the list, each with its own idling
  task automatic test_random_traffic(input int total);
    int done;
    int phase_len;
    int grow_pct;
    done = 0;
    while (done < total) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: grow_pct = 85;
        1: grow_pct = 50;
        default: grow_pct = 15;
      endcase
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        random_request(grow_pct);
        done++;
      end
    end
    tx_gaps_on = 1'b1;
  endtask

  // result side: check each beat against the oldest owed result, then pick
  // the next m_tready; the stall pattern steps through four modes as rx_cycle advances
  always @(posedge clk) begin : rx_side
    list_result_t got;
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (m_tvalid && m_tready) begin
        got = list_result_t'(m_tdata[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: unexpected beat %h", result_index, got);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.word !== want.word || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty ||
              got.full !== want.full) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: expected item %h status %0d count %0d empty %b full %b",
                       result_index, want.word, want.status, want.count, want.empty,
                       want.full);
              $display("result %0d: actual   item %h status %0d count %0d empty %b full %b",
                       result_index, got.word, got.status, got.count, got.empty, got.full);
            end
          end
        end
        result_index++;
      end
      if (hold_serial != hold_taken) begin
        hold_taken <= hold_serial;
        hold_left  <= LONG_HOLD;
        m_tready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= (rx_cycle % 4 == 0);
          default: m_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // watchdog: too long without a beat on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results owed", quiet_cycles,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_small_list();
    wait_results();
    test_full_list();
    wait_results();
    test_long_holdoff();
    wait_results();
    test_random_traffic(480);
    test_long_holdoff();
    test_random_traffic(480);
    wait_results();
    // let a late or extra beat show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
